// ----- sv/chm_pkg.sv -----
// Package for the chained hash map: sizes, command and status codes,
// memory word types and the bucket hash. No dependencies.
package chm_pkg;

    localparam int BUCKETS  = 1024;
    localparam int CAPACITY = 2048;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int ENT_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [ENT_W-1:0] head;
    } t_bucket;

    typedef struct packed {
        logic [31:0]      key;
        logic [15:0]      off;
        logic [31:0]      value;
        logic             nvalid;
        logic [ENT_W-1:0] next;
    } t_entry;

    // BUCKETS is a power of two: only the low bits of key*(off+1)+off matter.
    function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] key,
                                                   input logic [15:0] off);
        logic [31:0] prod;
        prod = 32'(key[BKT_W-1:0]) * (32'(off) + 32'd1) + 32'(off);
        return prod[BKT_W-1:0];
    endfunction

endpackage

// ----- sv/chained_hash_map.sv -----
// Chained hash map top level: bucket head memory, entry memory and the
// command sequencer. Depends on chm_pkg.
//
// Usage: drive i_cmd, i_key_id, i_bit_offset, i_value_in with start high;
// the request is taken at an edge where busy is low. Exactly one response
// follows: o_valid is high for one cycle with o_status and o_value_out.
// The receiver cannot stall; the response is taken the cycle it shows.
// Steps, from the accepting edge to the edge that takes o_valid:
//   unused command, or insert on a full table: answered from idle
//   insert: bucket read, then entry and bucket writes
//   find:   bucket read, head check, then one entry memory read per
//           chain entry visited; an empty bucket misses at the head check
//   clear:  one bucket head cleared per cycle, all BUCKETS heads
// busy is high while a request is at work; a new request may be taken
// in the cycle its predecessor's response shows.
// After reset the block sweeps all BUCKETS (1024) bucket heads
// with busy high and gives no response for that sweep.
module chained_hash_map import chm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_key_id,
    input  logic [15:0] i_bit_offset,
    input  logic [31:0] i_value_in,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_value_out
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CLR      = 3'd1;
    localparam logic [2:0] S_INS_RD   = 3'd2;
    localparam logic [2:0] S_INS_WR   = 3'd3;
    localparam logic [2:0] S_FND_BKT  = 3'd4;
    localparam logic [2:0] S_FND_HEAD = 3'd5;
    localparam logic [2:0] S_FND_ENT  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [BKT_W-1:0] r_clr, n_clr;
    logic             r_clr_rsp, n_clr_rsp;
    logic [CNT_W-1:0] r_count, n_count;
    logic [BKT_W-1:0] r_bkt, n_bkt;
    logic [31:0]      r_key, n_key;
    logic [15:0]      r_off, n_off;
    logic [31:0]      r_val, n_val;
    logic             r_valid, n_valid;
    logic [1:0]       r_status, n_status;
    logic [31:0]      r_vout, n_vout;

    t_bucket          bkt_mem [BUCKETS];
    logic             bkt_we, bkt_re;
    logic [BKT_W-1:0] bkt_waddr, bkt_raddr;
    t_bucket          bkt_wdata, bkt_rdata;

    t_entry           ent_mem [CAPACITY];
    logic             ent_we, ent_re;
    logic [ENT_W-1:0] ent_waddr, ent_raddr;
    t_entry           ent_wdata, ent_rdata;

    logic             accept;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        if (bkt_re) begin
            bkt_rdata <= bkt_mem[bkt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            ent_rdata <= ent_mem[ent_raddr];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_clr_rsp = r_clr_rsp;
        n_count   = r_count;
        n_bkt     = r_bkt;
        n_key     = r_key;
        n_off     = r_off;
        n_val     = r_val;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_vout    = r_vout;
        bkt_we    = 1'b0;
        bkt_waddr = r_bkt;
        bkt_wdata = '0;
        bkt_re    = 1'b0;
        bkt_raddr = r_bkt;
        ent_we    = 1'b0;
        ent_waddr = r_count[ENT_W-1:0];
        ent_wdata = '0;
        ent_re    = 1'b0;
        ent_raddr = ent_rdata.next;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key = i_key_id;
                    n_off = i_bit_offset;
                    n_val = i_value_in;
                    n_bkt = bucket_of(i_key_id, i_bit_offset);
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                                n_vout   = '0;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_FIND: begin
                            n_state = S_FND_BKT;
                        end
                        CMD_CLEAR: begin
                            n_count   = '0;
                            n_clr     = '0;
                            n_clr_rsp = 1'b1;
                            n_state   = S_CLR;
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = ST_OK;
                            n_vout   = '0;
                        end
                    endcase
                end
            end
            S_CLR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                    if (r_clr_rsp) begin
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_vout   = '0;
                    end
                end
            end
            S_INS_RD: begin
                bkt_re  = 1'b1;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                ent_we           = 1'b1;
                ent_wdata.key    = r_key;
                ent_wdata.off    = r_off;
                ent_wdata.value  = r_val;
                ent_wdata.nvalid = bkt_rdata.valid;
                ent_wdata.next   = bkt_rdata.head;
                bkt_we           = 1'b1;
                bkt_wdata.valid  = 1'b1;
                bkt_wdata.head   = r_count[ENT_W-1:0];
                n_count          = r_count + 1'b1;
                n_valid          = 1'b1;
                n_status         = ST_OK;
                n_vout           = '0;
                n_state          = S_IDLE;
            end
            S_FND_BKT: begin
                bkt_re  = 1'b1;
                n_state = S_FND_HEAD;
            end
            S_FND_HEAD: begin
                if (bkt_rdata.valid) begin
                    ent_re    = 1'b1;
                    ent_raddr = bkt_rdata.head;
                    n_state   = S_FND_ENT;
                end else begin
                    n_valid  = 1'b1;
                    n_status = ST_MISS;
                    n_vout   = '0;
                    n_state  = S_IDLE;
                end
            end
            S_FND_ENT: begin
                if (ent_rdata.key == r_key && ent_rdata.off == r_off) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_vout   = ent_rdata.value;
                    n_state  = S_IDLE;
                end else if (ent_rdata.nvalid) begin
                    ent_re = 1'b1;
                end else begin
                    n_valid  = 1'b1;
                    n_status = ST_MISS;
                    n_vout   = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_clr_rsp <= 1'b0;
            r_count   <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_rsp <= n_clr_rsp;
            r_count   <= n_count;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bkt    <= n_bkt;
        r_key    <= n_key;
        r_off    <= n_off;
        r_val    <= n_val;
        r_status <= n_status;
        r_vout   <= n_vout;
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_vout;

endmodule

// ----- sim/chained_hash_map_tb.sv -----
// Self-checking testbench for chained_hash_map: directed table, table-full fill, then random
// insert/find/clear/unused traffic checked by a behavioral map model. Depends on chm_pkg.
module chained_hash_map_tb;
    import chm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SCRIPT_LEN     = 22;
    localparam int KEY_POOL_MAX   = 64;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] value;
    } map_reply_t;

    typedef struct {
        logic [31:0] key;
        logic [15:0] off;
    } map_key_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [15:0] off;
        logic [31:0] val;
        bit          typed;
        logic [1:0]  status;
        logic [31:0] value;
    } script_row_t;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  i_cmd        = '0;
    logic [31:0] i_key_id     = '0;
    logic [15:0] i_bit_offset = '0;
    logic [31:0] i_value_in   = '0;
    logic        busy;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_value_out;

    chained_hash_map dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_key_id     (i_key_id),
        .i_bit_offset (i_bit_offset),
        .i_value_in   (i_value_in),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_value_out  (o_value_out)
    );

    // predictor state
    bit          head_valid [BUCKETS];
    int unsigned head_index [BUCKETS];
    bit [31:0]   ent_key    [CAPACITY];
    bit [15:0]   ent_off    [CAPACITY];
    bit [31:0]   ent_val    [CAPACITY];
    int unsigned ent_next   [CAPACITY];
    bit          ent_nvalid [CAPACITY];
    int unsigned ent_count;

    map_reply_t pending_replies[$];
    map_key_t   known_keys[$];
    int         mismatches;
    int         quiet_cycles;

    script_row_t script [SCRIPT_LEN] = '{
        '{CMD_FIND,   32'h0,        16'h0,    32'h0,        1'b1, ST_MISS, 32'h0},
        '{CMD_INSERT, 32'h0,        16'h0,    32'hFFFFFFFF, 1'b1, ST_OK,   32'h0},
        '{CMD_FIND,   32'h0,        16'h0,    32'h0,        1'b1, ST_OK,   32'hFFFFFFFF},
        '{CMD_INSERT, 32'hFFFFFFFF, 16'hFFFF, 32'h0,        1'b1, ST_OK,   32'h0},
        '{CMD_FIND,   32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, ST_OK,   32'h0},
        '{CMD_INSERT, 32'hFFFFFFFF, 16'hFFFF, 32'hA5A5A5A5, 1'b1, ST_OK,   32'h0},
        '{CMD_FIND,   32'hFFFFFFFF, 16'hFFFF, 32'h0,        1'b1, ST_OK,   32'hA5A5A5A5},
        '{CMD_FIND,   32'hFFFFFFFF, 16'hFFFE, 32'h0,        1'b0, ST_OK,   32'h0},
        '{CMD_INSERT, 32'd5,        16'h0,    32'd1,        1'b1, ST_OK,   32'h0},
        '{CMD_INSERT, 32'd1029,     16'h0,    32'd2,        1'b1, ST_OK,   32'h0},
        '{CMD_INSERT, 32'd2053,     16'h0,    32'd3,        1'b1, ST_OK,   32'h0},
        '{CMD_FIND,   32'd5,        16'h0,    32'h0,        1'b0, ST_OK,   32'h0},
        '{CMD_FIND,   32'd1029,     16'h0,    32'h0,        1'b0, ST_OK,   32'h0},
        '{CMD_FIND,   32'd3077,     16'h0,    32'h0,        1'b0, ST_OK,   32'h0},
        '{CMD_UNUSED, 32'h12345678, 16'hABCD, 32'hDEADBEEF, 1'b1, ST_OK,   32'h0},
        '{CMD_FIND,   32'd5,        16'h0,    32'h0,        1'b0, ST_OK,   32'h0},
        '{CMD_CLEAR,  32'h0,        16'h0,    32'h0,        1'b1, ST_OK,   32'h0},
        '{CMD_FIND,   32'h0,        16'h0,    32'h0,        1'b1, ST_MISS, 32'h0},
        '{CMD_FIND,   32'd5,        16'h0,    32'h0,        1'b1, ST_MISS, 32'h0},
        '{CMD_INSERT, 32'd5,        16'h0,    32'd7,        1'b1, ST_OK,   32'h0},
        '{CMD_FIND,   32'd5,        16'h0,    32'h0,        1'b0, ST_OK,   32'h0},
        '{CMD_FIND,   32'd1029,     16'h0,    32'h0,        1'b0, ST_OK,   32'h0}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned bucket_index(input logic [31:0] key, input logic [15:0] off);
        bit [63:0] h;
        h = {32'd0, key} * ({48'd0, off} + 64'd1) + {48'd0, off};
        return int'(h % 64'(BUCKETS));
    endfunction

    function automatic void map_apply(input logic [1:0] cmd, input logic [31:0] key,
                                      input logic [15:0] off, input logic [31:0] val,
                                      output logic [1:0] status, output logic [31:0] value);
        int unsigned b;
        int unsigned e;
        int unsigned steps;
        bit          live;
        status = ST_OK;
        value  = '0;
        case (cmd)
            CMD_INSERT: begin
                if (ent_count >= CAPACITY) begin
                    status = ST_FULL;
                end else begin
                    b = bucket_index(key, off);
                    e = ent_count;
                    ent_key[e]    = key;
                    ent_off[e]    = off;
                    ent_val[e]    = val;
                    ent_next[e]   = head_index[b];
                    ent_nvalid[e] = head_valid[b];
                    head_index[b] = e;
                    head_valid[b] = 1'b1;
                    ent_count     = e + 1;
                end
            end
            CMD_FIND: begin
                b      = bucket_index(key, off);
                live   = head_valid[b];
                e      = head_index[b];
                steps  = 0;
                status = ST_MISS;
                while (live && steps < ent_count && e < CAPACITY) begin
                    if (ent_key[e] == key && ent_off[e] == off) begin
                        status = ST_OK;
                        value  = ent_val[e];
                        break;
                    end
                    live = ent_nvalid[e];
                    e    = ent_next[e];
                    steps++;
                end
            end
            CMD_CLEAR: begin
                foreach (head_valid[i]) head_valid[i] = 1'b0;
                ent_count = 0;
            end
            default: ;
        endcase
    endfunction

    // Leaves start high on return; the caller lowers it for a pause.
    task automatic issue_request(input logic [1:0] cmd, input logic [31:0] key,
                                 input logic [15:0] off, input logic [31:0] val,
                                 input bit typed = 1'b0, input logic [1:0] typed_status = ST_OK,
                                 input logic [31:0] typed_value = '0);
        map_reply_t reply;
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_key_id     <= key;
        i_bit_offset <= off;
        i_value_in   <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        map_apply(cmd, key, off, val, reply.status, reply.value);
        if (typed) begin
            reply.status = typed_status;
            reply.value  = typed_value;
        end
        pending_replies.push_back(reply);
    endtask

    task automatic maybe_pause(input int pause_pct);
        if ($urandom_range(0, 99) < pause_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic remember_key(input logic [31:0] key, input logic [15:0] off);
        map_key_t k;
        k.key = key;
        k.off = off;
        known_keys.push_back(k);
        if (known_keys.size() > KEY_POOL_MAX) void'(known_keys.pop_front());
    endtask

    always @(posedge i_clk) begin
        map_reply_t want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: status %0d value_out %h", o_status, o_value_out);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_value_out !== want.value) begin
                    $error("value_out: expected %h, got %h", want.value, o_value_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int          sent;
        int          pick;
        int          phase_len;
        int          pause_pct;
        int          kidx;
        logic [31:0] key;
        logic [15:0] off;
        map_key_t    known;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            issue_request(script[i].cmd, script[i].key, script[i].off, script[i].val,
                          script[i].typed, script[i].status, script[i].value);
            maybe_pause(25);
        end
        drain_replies();

        // fill the entry store to capacity, then hit the full case
        issue_request(CMD_CLEAR, '0, '0, '0, 1'b1, ST_OK, '0);
        key = '0;
        off = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i % 8 != 7) begin
                key = $urandom;
                off = 16'($urandom_range(0, 65535));
            end
            issue_request(CMD_INSERT, key, off, $urandom);
            if (i % 64 == 0) remember_key(key, off);
        end
        issue_request(CMD_INSERT, 32'hFFFFFFFF, 16'hFFFF, 32'h12345678, 1'b1, ST_FULL, '0);
        issue_request(CMD_INSERT, $urandom, 16'($urandom_range(0, 65535)), $urandom,
                      1'b1, ST_FULL, '0);
        foreach (known_keys[i]) begin
            issue_request(CMD_FIND, known_keys[i].key, known_keys[i].off, $urandom);
            maybe_pause(20);
        end
        issue_request(CMD_FIND, $urandom, 16'($urandom_range(0, 65535)), $urandom);
        issue_request(CMD_UNUSED, $urandom, 16'($urandom_range(0, 65535)), $urandom,
                      1'b1, ST_OK, '0);
        drain_replies();
        issue_request(CMD_CLEAR, '0, '0, '0, 1'b1, ST_OK, '0);
        known_keys.delete();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 120);
            case ($urandom_range(0, 2))
                0: pause_pct = 0;
                1: pause_pct = 12;
                default: pause_pct = 35;
            endcase
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                if (sent > RANDOM_ITEMS - 250) pause_pct = 0;
                pick = $urandom_range(0, 99);
                kidx = 0;
                if (known_keys.size() == 0) begin
                    pick = 0;
                end else begin
                    kidx = $urandom_range(0, known_keys.size() - 1);
                end
                known.key = '0;
                known.off = '0;
                if (known_keys.size() != 0) known = known_keys[kidx];
                if (pick < 20) begin
                    key = $urandom;
                    off = 16'($urandom_range(0, 65535));
                    issue_request(CMD_INSERT, key, off, $urandom);
                    remember_key(key, off);
                end else if (pick < 30) begin
                    // same bucket, different key: grows a chain
                    key = known.key + 32'(1024 * $urandom_range(1, 7));
                    issue_request(CMD_INSERT, key, known.off, $urandom);
                    remember_key(key, known.off);
                end else if (pick < 40) begin
                    issue_request(CMD_INSERT, known.key, known.off, $urandom);
                end else if (pick < 80) begin
                    issue_request(CMD_FIND, known.key, known.off, $urandom);
                end else if (pick < 94) begin
                    issue_request(CMD_FIND, $urandom, 16'($urandom_range(0, 65535)), $urandom);
                end else begin
                    issue_request(CMD_UNUSED, $urandom, 16'($urandom_range(0, 65535)),
                                  $urandom);
                end
                sent++;
                maybe_pause(pause_pct);
            end
            if (sent <= RANDOM_ITEMS - 250 && $urandom_range(0, 3) == 0) begin
                drain_replies();
                issue_request(CMD_CLEAR, $urandom, 16'($urandom_range(0, 65535)), $urandom);
                known_keys.delete();
                sent++;
            end
        end

        drain_replies();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
